### sv/assert_macros.svh
// assertion macros shared by the frame parser rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HSFP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/hsfp_pkg.sv
// types, constants and helpers of the header sync frame parser
// used by the cfg registers, parse core and top of the block, depends on nothing
package hsfp_pkg;

	localparam int BYTE_W        = 8;
	localparam int POS_W         = 9;
	localparam int HDR_LEN       = 6;
	localparam int PAYLOAD_START = 9;
	localparam int CFG_IDX_W     = 2;

	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(6);
	localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(7);

	localparam logic [BYTE_W-1:0] SYNC_I = 8'h49;
	localparam logic [BYTE_W-1:0] SYNC_M = 8'h4D;
	localparam logic [BYTE_W-1:0] SYNC_P = 8'h50;
	localparam logic [BYTE_W-1:0] SYNC_R = 8'h52;
	localparam logic [BYTE_W-1:0] SYNC_O = 8'h4F;
	localparam logic [BYTE_W-1:0] SYNC_V = 8'h56;

	localparam logic [BYTE_W-1:0] RESET_EXPECTED_VERSION   = 8'd1;
	localparam logic [BYTE_W-1:0] RESET_COMMAND_FRAME_TYPE = 8'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPECTED_VERSION   = 2'd0,
		CFG_COMMAND_FRAME_TYPE = 2'd1
	} cfg_idx_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_OK        = 2'd0,
		VERDICT_CHECKSUM  = 2'd1,
		VERDICT_VER_TYPE  = 2'd2,
		VERDICT_MALFORMED = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [BYTE_W-1:0] expected_version;
		logic [BYTE_W-1:0] command_frame_type;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		kind_t             out_kind;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] byte_index;
		logic [BYTE_W-1:0] frame_length;
		verdict_t          verdict;
		logic [BYTE_W-1:0] command_code;
	} result_t;

	// expected header character at a header position
	function automatic logic [BYTE_W-1:0] sync_char(input logic [2:0] p);
		logic [BYTE_W-1:0] c;
		case (p)
			3'd0:    c = SYNC_I;
			3'd1:    c = SYNC_M;
			3'd2:    c = SYNC_P;
			3'd3:    c = SYNC_R;
			3'd4:    c = SYNC_O;
			3'd5:    c = SYNC_V;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

### sv/hsfp_stream_if.sv
// valid/ready stream channel used for the byte input and the result output
// payload type is set per instance, usually a struct from hsfp_pkg
interface hsfp_stream_if #(parameter type payload_t = logic [7:0]) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/hsfp_cfg_regs.sv
// configuration registers of the frame parser: version and command type
// depends on hsfp_pkg
module hsfp_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsfp_pkg::BYTE_W-1:0]     cfg_data,
	output hsfp_pkg::cfg_t                  cfg
);

	hsfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version   <= hsfp_pkg::RESET_EXPECTED_VERSION;
			cfg_q.command_frame_type <= hsfp_pkg::RESET_COMMAND_FRAME_TYPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsfp_pkg::CFG_EXPECTED_VERSION:   cfg_q.expected_version   <= cfg_data;
				hsfp_pkg::CFG_COMMAND_FRAME_TYPE: cfg_q.command_frame_type <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/hsfp_parse_core.sv
// frame parser state and per-byte step logic: header hunt, field capture,
// payload pass-through and checksum verdict; depends on hsfp_pkg
module hsfp_parse_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [hsfp_pkg::BYTE_W-1:0] rx_byte,
	input  hsfp_pkg::cfg_t              cfg,
	output logic                        res_gen,
	output hsfp_pkg::result_t           res_item
);

	logic [hsfp_pkg::POS_W-1:0]  pos_q, pos_n, idx_full;
	logic [hsfp_pkg::BYTE_W-1:0] sum_q, sum_n;
	logic [hsfp_pkg::BYTE_W-1:0] ver_q, ver_n, type_q, type_n, len_q, len_n;
	logic [hsfp_pkg::BYTE_W-1:0] cmd_q, cmd_n, inner_q, inner_n;
	logic [hsfp_pkg::BYTE_W-1:0] idx;
	logic                        too_short;

	assign idx_full  = pos_q - hsfp_pkg::POS_W'(hsfp_pkg::PAYLOAD_START);
	assign idx       = idx_full[hsfp_pkg::BYTE_W-1:0];
	// inner length plus its two leading bytes must fit in the payload
	assign too_short = (len_q < 8'd2) || (({1'b0, inner_q} + 9'd2) > {1'b0, len_q});

	always_comb begin
		pos_n    = pos_q;
		sum_n    = sum_q;
		ver_n    = ver_q;
		type_n   = type_q;
		len_n    = len_q;
		cmd_n    = cmd_q;
		inner_n  = inner_q;
		res_gen  = 1'b0;
		res_item = '0;
		if (pos_q < hsfp_pkg::POS_W'(hsfp_pkg::HDR_LEN)) begin
			if (rx_byte == hsfp_pkg::sync_char(pos_q[2:0])) begin
				sum_n = (pos_q == '0) ? rx_byte : sum_q + rx_byte;
				pos_n = pos_q + 1'b1;
			end else if (rx_byte == hsfp_pkg::SYNC_I) begin
				// mismatching 'I' may start a new header
				sum_n = rx_byte;
				pos_n = hsfp_pkg::POS_W'(1);
			end else begin
				sum_n = '0;
				pos_n = '0;
			end
		end else if (pos_q < hsfp_pkg::POS_W'(hsfp_pkg::PAYLOAD_START)) begin
			case (pos_q)
				hsfp_pkg::POS_VERSION: ver_n  = rx_byte;
				hsfp_pkg::POS_TYPE:    type_n = rx_byte;
				default: begin
					len_n   = rx_byte;
					cmd_n   = '0;
					inner_n = '0;
				end
			endcase
			sum_n = sum_q + rx_byte;
			pos_n = pos_q + 1'b1;
		end else if (idx < len_q) begin
			if (idx == 8'd0) begin
				cmd_n = rx_byte;
			end else if (idx == 8'd1) begin
				inner_n = rx_byte;
			end
			sum_n                 = sum_q + rx_byte;
			pos_n                 = pos_q + 1'b1;
			res_gen               = 1'b1;
			res_item.out_kind     = hsfp_pkg::KIND_PAYLOAD;
			res_item.data_byte    = rx_byte;
			res_item.byte_index   = idx;
			res_item.frame_length = len_q;
			res_item.verdict      = hsfp_pkg::VERDICT_OK;
		end else begin
			res_gen               = 1'b1;
			res_item.out_kind     = hsfp_pkg::KIND_VERDICT;
			res_item.frame_length = len_q;
			res_item.command_code = cmd_q;
			if (rx_byte != sum_q) begin
				res_item.verdict = hsfp_pkg::VERDICT_CHECKSUM;
			end else if (ver_q != cfg.expected_version || type_q != cfg.command_frame_type) begin
				res_item.verdict = hsfp_pkg::VERDICT_VER_TYPE;
			end else if (too_short) begin
				res_item.verdict = hsfp_pkg::VERDICT_MALFORMED;
			end else begin
				res_item.verdict = hsfp_pkg::VERDICT_OK;
			end
			pos_n = '0;
			sum_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			ver_q   <= '0;
			type_q  <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			inner_q <= '0;
		end else if (step) begin
			pos_q   <= pos_n;
			sum_q   <= sum_n;
			ver_q   <= ver_n;
			type_q  <= type_n;
			len_q   <= len_n;
			cmd_q   <= cmd_n;
			inner_q <= inner_n;
		end
	end

endmodule

### sv/header_sync_frame_parser.sv
// header sync frame parser top: input register, parse step, result register
// a byte accepted into the input register is parsed from there and its result loaded into the result register
// throughput: one byte per cycle unless a result is held back by a full result register
// a byte that yields a result waits in the input register only while the result register is full and res.ready is low
// reset: arst_n low clears parser state, valid flags and loads register defaults 1 and 3
// depends on hsfp_pkg, hsfp_stream_if, hsfp_cfg_regs, hsfp_parse_core, assert_macros.svh
`include "assert_macros.svh"

module header_sync_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsfp_pkg::BYTE_W-1:0]     cfg_data,
	hsfp_stream_if.sink                     rx,
	hsfp_stream_if.source                   res
);

	hsfp_pkg::cfg_t              cfg;
	logic                        valid_s1;
	logic [hsfp_pkg::BYTE_W-1:0] byte_s1;
	logic                        valid_s2;
	hsfp_pkg::result_t           res_s2;
	logic                        res_gen;
	hsfp_pkg::result_t           res_item;
	logic                        slot_free;
	logic                        step_go;

	hsfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsfp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step_go),
		.rx_byte  (byte_s1),
		.cfg      (cfg),
		.res_gen  (res_gen),
		.res_item (res_item)
	);

	assign slot_free = !valid_s2 || res.ready;
	assign step_go   = valid_s1 && (!res_gen || slot_free);
	assign rx.ready  = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (step_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step_go && res_gen) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && res_gen) begin
			res_s2 <= res_item;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	// a stalled byte stays put until the parser consumes it
	`HSFP_ASSERT_NEXT(a_s1_hold, valid_s1 && !step_go, valid_s1 && $stable(byte_s1), "input stage lost a stalled byte")
	`HSFP_ASSERT_IMPL(a_payload_fields, valid_s2 && res_s2.out_kind == hsfp_pkg::KIND_PAYLOAD, res_s2.verdict == hsfp_pkg::VERDICT_OK && res_s2.command_code == '0 && res_s2.byte_index < res_s2.frame_length, "payload result fields inconsistent")
	`HSFP_ASSERT_IMPL(a_verdict_fields, valid_s2 && res_s2.out_kind == hsfp_pkg::KIND_VERDICT, res_s2.data_byte == '0 && res_s2.byte_index == '0, "verdict result carries payload fields")
	`HSFP_ASSERT_NEXT(a_cfg_version, cfg_we && cfg_index == hsfp_pkg::CFG_EXPECTED_VERSION, cfg.expected_version == $past(cfg_data), "version register write lost")

endmodule
